// ----- hw/rtl/upd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URL percent decoder
// Character codes, escape phases, the decode command word and the hex digit
// helper.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CASE_MASK  = 8'hDF;
    localparam logic [7:0] TEN        = 8'd10;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PCT    = 3'd1,
        PH_PCT_HI = 3'd2,
        PH_BS     = 3'd3,
        PH_BSX    = 3'd4,
        PH_BSX_HI = 3'd5
    } t_phase;

    // Up to three decoded bytes caused by one input word.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_cmd;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UPPER_A) begin
            v = (c & CASE_MASK) - CH_UPPER_A + TEN;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

    // Character decoded alone: only plus maps.
    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

// ----- hw/rtl/upd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front: escape tracker
// Classifies each accepted character against the escape phase and emits one
// command of zero to three decoded bytes.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_push,
    output upd_pkg::t_cmd  o_cmd
);

    upd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_high, n_high;
    logic [7:0]      dv;
    logic [7:0]      dec;

    assign dv  = upd_pkg::digit_value(i_byte);
    assign dec = {r_high, 4'b0000} + dv;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                n_phase = upd_pkg::PH_PCT_HI;
                n_high  = dv[3:0];
            end
            upd_pkg::PH_PCT_HI, upd_pkg::PH_BSX_HI: begin
                n_phase = upd_pkg::PH_IDLE;
            end
            upd_pkg::PH_BS: begin
                if (i_byte == upd_pkg::CH_X) begin
                    n_phase = upd_pkg::PH_BSX;
                end else if (i_byte == upd_pkg::CH_PERCENT) begin
                    n_phase = upd_pkg::PH_PCT;
                end else if (i_byte == upd_pkg::CH_BSLASH) begin
                    n_phase = upd_pkg::PH_BS;
                end else begin
                    n_phase = upd_pkg::PH_IDLE;
                end
            end
            upd_pkg::PH_BSX: begin
                n_phase = upd_pkg::PH_BSX_HI;
                n_high  = dv[3:0];
            end
            default: begin
                if (i_byte == upd_pkg::CH_PERCENT) begin
                    n_phase = upd_pkg::PH_PCT;
                end else if (i_byte == upd_pkg::CH_BSLASH) begin
                    n_phase = upd_pkg::PH_BS;
                end else begin
                    n_phase = upd_pkg::PH_IDLE;
                end
            end
        endcase
        // End of string drops any pending escape
        if (i_last) begin
            n_phase = upd_pkg::PH_IDLE;
            n_high  = 4'd0;
        end
    end

    // Command output
    always_comb begin
        o_cmd       = '0;
        o_cmd.last  = i_last;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (i_last) begin
                    o_cmd.bytes[0] = upd_pkg::CH_PERCENT;
                    o_cmd.bytes[1] = upd_pkg::plain(i_byte);
                    o_cmd.cnt      = 2'd2;
                end
            end
            upd_pkg::PH_PCT_HI, upd_pkg::PH_BSX_HI: begin
                o_cmd.bytes[0] = dec;
                o_cmd.cnt      = 2'd1;
            end
            upd_pkg::PH_BS: begin
                o_cmd.bytes[0] = upd_pkg::CH_BSLASH;
                if (i_byte == upd_pkg::CH_X) begin
                    if (i_last) begin
                        o_cmd.bytes[1] = upd_pkg::CH_X;
                        o_cmd.cnt      = 2'd2;
                    end
                end else if (i_last) begin
                    o_cmd.bytes[1] = upd_pkg::plain(i_byte);
                    o_cmd.cnt      = 2'd2;
                end else if (i_byte == upd_pkg::CH_PERCENT ||
                             i_byte == upd_pkg::CH_BSLASH) begin
                    o_cmd.cnt = 2'd1;
                end else begin
                    o_cmd.bytes[1] = upd_pkg::plain(i_byte);
                    o_cmd.cnt      = 2'd2;
                end
            end
            upd_pkg::PH_BSX: begin
                if (i_last) begin
                    o_cmd.bytes[0] = upd_pkg::CH_BSLASH;
                    o_cmd.bytes[1] = upd_pkg::CH_X;
                    o_cmd.bytes[2] = upd_pkg::plain(i_byte);
                    o_cmd.cnt      = 2'd3;
                end
            end
            default: begin
                o_cmd.bytes[0] = upd_pkg::plain(i_byte);
                if (i_last || !(i_byte == upd_pkg::CH_PERCENT ||
                                i_byte == upd_pkg::CH_BSLASH)) begin
                    o_cmd.cnt = 2'd1;
                end
            end
        endcase
    end

    assign o_push = i_accept && (o_cmd.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_high  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

endmodule

// ----- hw/rtl/upd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue: command queue
// Small register FIFO of decode commands between tracker and emitter.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  upd_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output upd_pkg::t_cmd  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/upd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back: byte emitter
// Walks head-command bytes to the output register, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  upd_pkg::t_cmd  i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign load   = !i_empty && (!r_valid || i_out_ready);
    assign at_end = (r_idx == i_head.cnt - 2'd1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= i_head.last && at_end;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_last  = r_last;

endmodule

// ----- hw/rtl/url_percent_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes plus, percent escapes and backslash-x escapes, one character a word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one raw character per word,
//   i_in_last marking the final character of a string. Output channel
//   (o_out_valid / i_out_ready) gives one decoded byte per word, o_out_last on
//   the final decoded byte of the string.
//   The word that completes a decoded byte pushes it into the command queue;
//   the emitter then loads it into the output register that drives o_out_byte.
//   Throughput: one input word per cycle while the queue has room; the emitter
//   moves one byte per cycle unless the output stalls. A word can release two
//   or three bytes (a backslash then a non-x, non-escape character, or a final
//   character that flushes a partial escape); prefix characters produce none.
//   Stalls: the command queue (QUEUE_DEPTH entries) absorbs output stalls;
//   o_in_ready drops only when the queue is full.
//   Reset (i_rst_n low, synchronous): clears the escape phase, empties the
//   queue and drops o_out_valid.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    upd_pkg::t_cmd cmd;
    upd_pkg::t_cmd head;

    // Hold the input off only when no queue slot is free
    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming URL percent decoder
// Feeds encoded strings (plus signs, percent and backslash-x escapes, broken
// and truncated escapes, raw bytes) with random gaps on the input side and
// random back-pressure on the output side. A scoreboard decodes every
// accepted word on its own and compares each decoded word in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         RANDOM_ITEMS = 305;
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         SETTLE_CYCLES = 12;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;

    // One decoded word as the block should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_word;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the escape state of the stream and keeps the decoded
    // words still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class upd_scoreboard;
        upd_pkg::t_phase esc_phase;
        logic [3:0]      hi_nib;
        t_dec_word       decoded_q[$];
        logic [7:0]      step_q[$];
        int              errors;

        function new();
            esc_phase = upd_pkg::PH_IDLE;
            hi_nib    = 4'h0;
            errors    = 0;
        endfunction

        // Digit value of any character, no validity check, modulo 256.
        function logic [7:0] hex_nibble(logic [7:0] c);
            return (c >= upd_pkg::CH_UPPER_A)
                ? ((c & upd_pkg::CASE_MASK) + upd_pkg::TEN - upd_pkg::CH_UPPER_A)
                : (c - upd_pkg::CH_ZERO);
        endfunction

        function logic [7:0] plain_char(logic [7:0] c);
            return (c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c;
        endfunction

        function void idle_char(logic [7:0] c, logic lst);
            if (lst) begin
                step_q.push_back(plain_char(c));
            end else if (c == upd_pkg::CH_PLUS) begin
                step_q.push_back(upd_pkg::CH_SPACE);
            end else if (c == upd_pkg::CH_PERCENT) begin
                esc_phase = upd_pkg::PH_PCT;
            end else if (c == upd_pkg::CH_BSLASH) begin
                esc_phase = upd_pkg::PH_BS;
            end else begin
                step_q.push_back(c);
            end
        endfunction

        // Note one accepted input word and queue the decoded words it causes.
        function void decode_char(logic [7:0] c, logic lst);
            t_dec_word  w;
            logic [7:0] dv;
            step_q.delete();
            dv = hex_nibble(c);
            case (esc_phase)
                upd_pkg::PH_PCT: begin
                    if (lst) begin
                        step_q.push_back(upd_pkg::CH_PERCENT);
                        step_q.push_back(plain_char(c));
                    end else begin
                        hi_nib    = dv[3:0];
                        esc_phase = upd_pkg::PH_PCT_HI;
                    end
                end
                upd_pkg::PH_PCT_HI, upd_pkg::PH_BSX_HI: begin
                    step_q.push_back({hi_nib, 4'h0} + dv);
                    esc_phase = upd_pkg::PH_IDLE;
                end
                upd_pkg::PH_BS: begin
                    if (c == upd_pkg::CH_X && lst) begin
                        step_q.push_back(upd_pkg::CH_BSLASH);
                        step_q.push_back(upd_pkg::CH_X);
                    end else if (c == upd_pkg::CH_X) begin
                        esc_phase = upd_pkg::PH_BSX;
                    end else begin
                        // backslash without x: emit it raw, then restart
                        step_q.push_back(upd_pkg::CH_BSLASH);
                        esc_phase = upd_pkg::PH_IDLE;
                        idle_char(c, lst);
                    end
                end
                upd_pkg::PH_BSX: begin
                    if (lst) begin
                        step_q.push_back(upd_pkg::CH_BSLASH);
                        step_q.push_back(upd_pkg::CH_X);
                        step_q.push_back(plain_char(c));
                    end else begin
                        hi_nib    = dv[3:0];
                        esc_phase = upd_pkg::PH_BSX_HI;
                    end
                end
                default: begin
                    esc_phase = upd_pkg::PH_IDLE;
                    idle_char(c, lst);
                end
            endcase
            foreach (step_q[i]) begin
                w.data = step_q[i];
                w.last = lst && (i == step_q.size() - 1);
                decoded_q.push_back(w);
            end
            // end of string clears any escape state
            if (lst) begin
                esc_phase = upd_pkg::PH_IDLE;
                hi_nib    = 4'h0;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Check one decoded word taken from the block.
        task compare_byte(logic [7:0] b, logic l);
            t_dec_word exp_w;
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected word %02h last %0b", b, l));
            end else begin
                exp_w = decoded_q.pop_front();
                if (b !== exp_w.data) begin
                    report($sformatf("byte %02h, want %02h", b, exp_w.data));
                end
                if (l !== exp_w.last) begin
                    report($sformatf("last %0b on byte %02h, want %0b", l, b,
                                     exp_w.last));
                end
            end
        endtask

        task check_leftover();
            if (decoded_q.size() != 0) begin
                report($sformatf("%0d decoded words never came", decoded_q.size()));
            end
        endtask

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    upd_scoreboard sb;
    logic [7:0]    str_q[$];
    int            items_sent;
    int            cycles;
    bit            in_steady;   // no input gaps while set
    bit            out_steady;  // no output stalls while set

    always #5 i_clk = ~i_clk;

    url_percent_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    // Bail out if the run hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, and check every word taken.
    // ------------------------------------------------------------------------
    initial begin : out_ready_drive
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                hold = pick_gap(out_steady);
            end
        end
    end

    // Ready and valid are read before this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.compare_byte(o_out_byte, o_out_last);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Present one word after an optional gap; hold it until accepted.
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap(in_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= l;
        do @(posedge i_clk); while (!o_in_ready);
        sb.decode_char(b, l);
        items_sent++;
    endtask

    // Drop valid at the current edge and wait out everything owed.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        // prefix characters leave no word behind: allow the pipeline to settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Send the built string, last mark on its final character.
    task automatic send_string();
        foreach (str_q[i]) begin
            send_word(str_q[i], i == str_q.size() - 1);
        end
        str_q.delete();
    endtask

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return upd_pkg::CH_ZERO + 8'(r);
        end else if (r < 16) begin
            return CH_LOWER_A + 8'(r - 10);
        end
        return upd_pkg::CH_UPPER_A + 8'(r - 16);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_not_x();
        logic [7:0] c;
        c = rand_byte();
        return (c == upd_pkg::CH_X) ? upd_pkg::CH_PLUS : c;
    endfunction

    // Append one token: mostly well-formed, some broken or raw noise.
    function automatic void add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            str_q.push_back(rand_byte());
        end else if (r < 38) begin
            str_q.push_back(upd_pkg::CH_PLUS);
        end else if (r < 58) begin
            str_q.push_back(upd_pkg::CH_PERCENT);
            str_q.push_back(rand_hex());
            str_q.push_back(rand_hex());
        end else if (r < 74) begin
            str_q.push_back(upd_pkg::CH_BSLASH);
            str_q.push_back(upd_pkg::CH_X);
            str_q.push_back(rand_hex());
            str_q.push_back(rand_hex());
        end else if (r < 80) begin
            // unchecked digits: any byte at all
            str_q.push_back(upd_pkg::CH_PERCENT);
            str_q.push_back(rand_byte());
            str_q.push_back(rand_byte());
        end else if (r < 86) begin
            str_q.push_back(upd_pkg::CH_BSLASH);
            str_q.push_back(rand_not_x());
        end else if (r < 91) begin
            str_q.push_back(upd_pkg::CH_BSLASH);
            str_q.push_back(upd_pkg::CH_X);
        end else if (r < 96) begin
            str_q.push_back(upd_pkg::CH_PERCENT);
            if ($urandom_range(0, 1)) str_q.push_back(rand_hex());
        end else begin
            str_q.push_back(upd_pkg::CH_BSLASH);
            str_q.push_back(upd_pkg::CH_X);
            str_q.push_back(rand_hex());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int n_tok;
        sb         = new();
        items_sent = 0;
        cycles     = 0;
        in_steady  = 1'b0;
        out_steady = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Raw zero, then high bytes as unchecked digits
        str_q = '{8'h00, upd_pkg::CH_PERCENT, 8'hFF, 8'h80};
        send_string();
        // Plus, mixed-case percent escape, decoded zero byte at the end
        str_q = '{upd_pkg::CH_PLUS, upd_pkg::CH_PERCENT, 8'h46, 8'h66,
                  upd_pkg::CH_PERCENT, upd_pkg::CH_ZERO, upd_pkg::CH_ZERO};
        send_string();
        // Backslash-x escape, then backslash without x as the final pair
        str_q = '{upd_pkg::CH_BSLASH, upd_pkg::CH_X, 8'h34, 8'h31,
                  upd_pkg::CH_BSLASH, 8'h71};
        send_string();
        // String ends inside escapes: flush held prefix characters
        str_q = '{upd_pkg::CH_PERCENT, upd_pkg::CH_PLUS};
        send_string();
        str_q = '{upd_pkg::CH_BSLASH, upd_pkg::CH_X, 8'h5A};
        send_string();
        str_q = '{upd_pkg::CH_BSLASH, upd_pkg::CH_X};
        send_string();
        // Final character opens an escape
        str_q = '{upd_pkg::CH_PERCENT};
        send_string();
        str_q = '{upd_pkg::CH_BSLASH};
        send_string();
        // hold off until the block has caught up completely
        drain();

        while (items_sent < RANDOM_ITEMS + 26) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 7) == 0) in_steady = ~in_steady;
            if ($urandom_range(0, 7) == 0) out_steady = ~out_steady;
            n_tok = $urandom_range(1, 6);
            repeat (n_tok) add_token();
            send_string();
            if ($urandom_range(0, 11) == 0) drain();
        end

        drain();
        sb.check_leftover();
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
